/* hw/rtl/shabsh_pkg.sv */
// SHA-256 byte stream hasher: shared types and constants.
// Round constants and initial hash values. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package shabsh_pkg;

   typedef logic [31:0] word_type;
   typedef logic [7:0]  byte_type;

   localparam int unsigned NUM_ROUNDS  = 64;
   localparam int unsigned NUM_HASH    = 8;
   localparam int unsigned BLOCK_WORDS = 16;

   localparam byte_type   PAD_BYTE  = 8'h80;
   localparam logic [5:0] PAD_FILL  = 6'd56;
   localparam logic [5:0] FILL_LAST = 6'd63;

   localparam word_type ROUND_K [NUM_ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam word_type HASH_INIT [NUM_HASH] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

endpackage

`default_nettype wire

/* hw/rtl/shabsh_ifs.sv */
// Valid/ready channel interfaces for the byte stream hasher.
// Request carries message bytes, response carries digest words. Uses shabsh_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface shabsh_req_if;
   import shabsh_pkg::*;

   logic     valid;
   logic     ready;
   byte_type data_byte;
   logic     has_byte;
   logic     last;

   modport source (output valid, output data_byte, output has_byte, output last,
                   input ready);
   modport sink   (input valid, input data_byte, input has_byte, input last,
                   output ready);
endinterface

interface shabsh_rsp_if;
   import shabsh_pkg::*;

   logic       valid;
   logic       ready;
   word_type   digest_word;
   logic [2:0] word_index;
   logic       final_word;

   modport source (output valid, output digest_word, output word_index,
                   output final_word, input ready);
   modport sink   (input valid, input digest_word, input word_index,
                   input final_word, output ready);
endinterface

`default_nettype wire

/* hw/rtl/sha256_byte_stream_hasher_unit.sv */
// SHA-256 over a byte stream: one round unit reused 64 times per block.
// A byte goes into the block buffer; a full block then runs the rounds and the hash update.
// A last word adds the padding bytes (9 to 72), their rounds, then 8 words out.
// New bytes are accepted only while idle, not while the single round unit works or digest words go out.
// Reset (synchronous, active high): initial hash values, zero length and fill, idle.
`timescale 1ns / 1ps
`default_nettype none

module sha256_byte_stream_hasher_unit (
   input  wire logic         clock,
   input  wire logic         reset,
   shabsh_req_if.sink        req_chan,
   shabsh_rsp_if.source      rsp_chan
);
   import shabsh_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_UPDATE,
      ST_PAD,
      ST_EMIT
   } state_type;

   function automatic word_type ror(input word_type x, input int unsigned n);
      ror = (x >> n) | (x << (32 - n));
   endfunction

   state_type   state_ff, state_in;
   word_type    hash_ff [NUM_HASH];
   word_type    hash_in [NUM_HASH];
   word_type    v_ff [NUM_HASH];
   word_type    v_in [NUM_HASH];
   word_type    w_ff [BLOCK_WORDS];
   word_type    w_in [BLOCK_WORDS];
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] length_ff, length_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic        fin_ff, fin_in;          // message end seen, padding pending
   logic        sent80_ff, sent80_in;
   logic        lenph_ff, lenph_in;      // emitting length bytes
   logic [2:0]  len_idx_ff, len_idx_in;
   logic        pad_done_ff, pad_done_in;
   logic [2:0]  emit_idx_ff, emit_idx_in;

   logic        push_en;
   byte_type    push_byte;
   word_type    t1, t2, sig0, sig1, ch, maj, s0, s1, w_new;

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = (state_ff == ST_EMIT);
   assign rsp_chan.digest_word = hash_ff[emit_idx_ff];
   assign rsp_chan.word_index  = emit_idx_ff;
   assign rsp_chan.final_word  = (emit_idx_ff == 3'd7);

   // round datapath
   always_comb begin
      sig1  = ror(v_ff[4], 6) ^ ror(v_ff[4], 11) ^ ror(v_ff[4], 25);
      ch    = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1    = v_ff[7] + sig1 + ch + ROUND_K[rnd_ff] + w_ff[0];
      sig0  = ror(v_ff[0], 2) ^ ror(v_ff[0], 13) ^ ror(v_ff[0], 22);
      maj   = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2    = sig0 + maj;
      s0    = ror(w_ff[1], 7) ^ ror(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1    = ror(w_ff[14], 17) ^ ror(w_ff[14], 19) ^ (w_ff[14] >> 10);
      w_new = w_ff[0] + s0 + w_ff[9] + s1;
   end

   always_comb begin
      state_in    = state_ff;
      hash_in     = hash_ff;
      v_in        = v_ff;
      w_in        = w_ff;
      fill_in     = fill_ff;
      length_in   = length_ff;
      rnd_in      = rnd_ff;
      fin_in      = fin_ff;
      sent80_in   = sent80_ff;
      lenph_in    = lenph_ff;
      len_idx_in  = len_idx_ff;
      pad_done_in = pad_done_ff;
      emit_idx_in = emit_idx_ff;
      push_en     = 1'b0;
      push_byte   = req_chan.data_byte;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.has_byte) begin
                  push_en   = 1'b1;
                  length_in = length_ff + 64'd8;
               end
               if (req_chan.last) begin
                  fin_in   = 1'b1;
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            push_en = 1'b1;
            if (!sent80_ff) begin
               push_byte = PAD_BYTE;
               sent80_in = 1'b1;
            end else if (lenph_ff || fill_ff == PAD_FILL) begin
               // big-endian length, most significant byte first
               push_byte  = length_ff[{~len_idx_ff, 3'b111} -: 8];
               lenph_in   = 1'b1;
               len_idx_in = len_idx_ff + 3'd1;
               if (len_idx_ff == 3'd7) begin
                  pad_done_in = 1'b1;
               end
            end else begin
               push_byte = '0;
            end
         end
         ST_ROUND: begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
               w_in[i] = w_ff[i + 1];
            end
            w_in[BLOCK_WORDS - 1] = w_new;
            v_in[7] = v_ff[6];
            v_in[6] = v_ff[5];
            v_in[5] = v_ff[4];
            v_in[4] = v_ff[3] + t1;
            v_in[3] = v_ff[2];
            v_in[2] = v_ff[1];
            v_in[1] = v_ff[0];
            v_in[0] = t1 + t2;
            rnd_in  = rnd_ff + 6'd1;
            if (rnd_ff == FILL_LAST) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            for (int i = 0; i < NUM_HASH; i++) begin
               hash_in[i] = hash_ff[i] + v_ff[i];
            end
            if (pad_done_ff) begin
               emit_idx_in = '0;
               state_in    = ST_EMIT;
            end else if (fin_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (rsp_chan.ready) begin
               emit_idx_in = emit_idx_ff + 3'd1;
               if (emit_idx_ff == 3'd7) begin
                  hash_in     = HASH_INIT;
                  fill_in     = '0;
                  length_in   = '0;
                  fin_in      = 1'b0;
                  sent80_in   = 1'b0;
                  lenph_in    = 1'b0;
                  len_idx_in  = '0;
                  pad_done_in = 1'b0;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // shared byte path into the block buffer; a full block starts the rounds
      if (push_en) begin
         for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
            w_in[i] = {w_ff[i][23:0], w_ff[i + 1][31:24]};
         end
         w_in[BLOCK_WORDS - 1] = {w_ff[BLOCK_WORDS - 1][23:0], push_byte};
         fill_in = fill_ff + 6'd1;
         if (fill_ff == FILL_LAST) begin
            fill_in  = '0;
            v_in     = hash_ff;
            rnd_in   = '0;
            state_in = ST_ROUND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         hash_ff     <= HASH_INIT;
         fill_ff     <= '0;
         length_ff   <= '0;
         rnd_ff      <= '0;
         fin_ff      <= 1'b0;
         sent80_ff   <= 1'b0;
         lenph_ff    <= 1'b0;
         len_idx_ff  <= '0;
         pad_done_ff <= 1'b0;
         emit_idx_ff <= '0;
      end else begin
         state_ff    <= state_in;
         hash_ff     <= hash_in;
         fill_ff     <= fill_in;
         length_ff   <= length_in;
         rnd_ff      <= rnd_in;
         fin_ff      <= fin_in;
         sent80_ff   <= sent80_in;
         lenph_ff    <= lenph_in;
         len_idx_ff  <= len_idx_in;
         pad_done_ff <= pad_done_in;
         emit_idx_ff <= emit_idx_in;
      end
      v_ff <= v_in;
      w_ff <= w_in;
   end

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking bench for sha256_byte_stream_hasher_unit: a local SHA-256 model predicts digests.
// Depends on shabsh_pkg (types, round constants, initial hash) and shabsh_ifs.
`timescale 1ns / 1ps

module tb_top;
   import shabsh_pkg::*;

   localparam int unsigned ITEM_TARGET      = 430;
   localparam int unsigned QUIET_AFTER      = 375;
   localparam int unsigned HOLD_AFTER_WORDS = 64;
   localparam int unsigned HOLD_OFF_CYCLES  = 400;
   localparam int unsigned STALL_LIMIT      = 4000;
   localparam int unsigned DRAIN_CYCLES     = 400;
   localparam int unsigned REPORT_MAX       = 10;

   class digest_scoreboard;
      typedef struct {
         word_type   digest_word;
         logic [2:0] word_index;
         logic       final_word;
      } digest_entry_type;

      word_type         hash_state [NUM_HASH];
      byte_type         block_bytes [64];
      int unsigned      fill;
      logic [63:0]      msg_bits;
      digest_entry_type pending_words [$];
      int unsigned      failures;
      int unsigned      words_checked;

      function new();
         failures      = 0;
         words_checked = 0;
         restart_message();
      endfunction

      function void restart_message();
         hash_state = HASH_INIT;
         fill       = 0;
         msg_bits   = '0;
      endfunction

      function word_type rotr(word_type x, int unsigned n);
         return (x >> n) | (x << (32 - n));
      endfunction

      function void compress_block();
         word_type sched [64];
         word_type v [NUM_HASH];
         word_type s0, s1, t1, t2;
         for (int i = 0; i < BLOCK_WORDS; i++)
            sched[i] = {block_bytes[4*i], block_bytes[4*i+1],
                        block_bytes[4*i+2], block_bytes[4*i+3]};
         for (int i = BLOCK_WORDS; i < NUM_ROUNDS; i++) begin
            s0 = rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3);
            s1 = rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10);
            sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
         end
         v = hash_state;
         for (int i = 0; i < NUM_ROUNDS; i++) begin
            s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
            t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + sched[i];
            s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
            t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
         end
         for (int i = 0; i < NUM_HASH; i++)
            hash_state[i] += v[i];
      endfunction

      function void load_byte(byte_type b);
         block_bytes[fill] = b;
         if (fill == FILL_LAST) begin
            compress_block();
            fill = 0;
         end else begin
            fill++;
         end
      endfunction

      // one accepted request word; a last word closes the message and queues 8 digest words
      function void absorb_word(byte_type data, logic has_byte, logic last);
         logic [63:0]      len;
         digest_entry_type entry;
         if (has_byte) begin
            load_byte(data);
            msg_bits += 64'd8;
         end
         if (!last)
            return;
         len = msg_bits;
         load_byte(PAD_BYTE);
         while (fill != PAD_FILL)
            load_byte(8'h00);
         for (int i = 0; i < 8; i++)
            load_byte(len[63 - 8*i -: 8]);
         for (int i = 0; i < NUM_HASH; i++) begin
            entry.digest_word = hash_state[i];
            entry.word_index  = 3'(i);
            entry.final_word  = (i == NUM_HASH - 1);
            pending_words = {pending_words, entry};
         end
         restart_message();
      endfunction

      function void note_failure(string what);
         failures++;
         if (failures <= REPORT_MAX)
            $display("[%0t] %s", $realtime, what);
      endfunction

      function void check_digest_word(word_type w, logic [2:0] idx, logic fin);
         digest_entry_type want;
         words_checked++;
         if (pending_words.size() == 0) begin
            note_failure($sformatf("unexpected digest word %h index %0d final %b", w, idx, fin));
            return;
         end
         want = pending_words.pop_front();
         if (w !== want.digest_word || idx !== want.word_index || fin !== want.final_word)
            note_failure($sformatf("digest word mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                                   want.digest_word, want.word_index, want.final_word,
                                   w, idx, fin));
      endfunction

      function int unsigned pending_count();
         return pending_words.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   shabsh_req_if req_if ();
   shabsh_rsp_if rsp_if ();

   sha256_byte_stream_hasher_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   digest_scoreboard sb;
   int unsigned items_sent   = 0;
   bit          quiet        = 1'b0;
   bit          tx_gappy     = 1'b0;
   bit          hold_done    = 1'b0;
   bit          rx_gappy     = 1'b0;
   int unsigned rx_window    = 0;
   int unsigned rx_stall_left = 0;
   int unsigned idle_cycles  = 0;
   int unsigned pad_edge_lengths [7] = '{55, 56, 57, 63, 64, 119, 120};

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // handshake monitor and stall watchdog
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_if.valid && req_if.ready)
            sb.absorb_word(req_if.data_byte, req_if.has_byte, req_if.last);
         if (rsp_if.valid && rsp_if.ready)
            sb.check_digest_word(rsp_if.digest_word, rsp_if.word_index, rsp_if.final_word);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // response side: random stall bursts, plus one long hold-off once enough words came back
   always @(negedge clock) begin
      if (!hold_done && sb != null && sb.words_checked >= HOLD_AFTER_WORDS) begin
         hold_done     = 1'b1;
         rx_stall_left = HOLD_OFF_CYCLES;
      end
      if (rx_window == 0) begin
         rx_window = 48;
         rx_gappy  = ($urandom_range(0, 2) != 0);
      end else begin
         rx_window--;
      end
      if (rx_stall_left != 0) begin
         rsp_if.ready <= 1'b0;
         rx_stall_left--;
      end else if (!quiet && rx_gappy && $urandom_range(0, 5) == 0) begin
         rx_stall_left = $urandom_range(1, 12) - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // called at a falling edge, returns at the falling edge after the word is taken
   task automatic send_word(input byte_type d, input logic hb, input logic lst);
      if (!quiet && tx_gappy && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= d;
      req_if.has_byte  <= hb;
      req_if.last      <= lst;
      do
         @(posedge clock);
      while (!req_if.ready);
      @(negedge clock);
   endtask

   // random message of n_bytes; the closing word carries the final byte when tail_byte is set and n_bytes is not zero
   task automatic send_message(input int unsigned n_bytes, input bit tail_byte);
      for (int k = 0; k < n_bytes; k++) begin
         if ($urandom_range(0, 9) == 0) begin
            send_word(byte_type'($urandom_range(0, 255)), 1'b0, 1'b0);
            items_sent++;
         end
         send_word(byte_type'($urandom_range(0, 255)), 1'b1, tail_byte && (k == n_bytes - 1));
         items_sent++;
      end
      if (!tail_byte || n_bytes == 0) begin
         send_word(byte_type'($urandom_range(0, 255)), 1'b0, 1'b1);
         items_sent++;
      end
   endtask

   initial begin
      int unsigned n;
      req_if.valid     = 1'b0;
      req_if.data_byte = '0;
      req_if.has_byte  = 1'b0;
      req_if.last      = 1'b0;
      rsp_if.ready     = 1'b0;
      reset            = 1'b1;
      sb = new();
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // empty message, ignored words, one-byte messages, "abc", close without a byte
      send_word(8'h00, 1'b0, 1'b1);
      send_word(8'hff, 1'b0, 1'b0);
      send_word(8'h00, 1'b1, 1'b1);
      send_word(8'hff, 1'b1, 1'b1);
      send_word(8'h61, 1'b1, 1'b0);
      send_word(8'h62, 1'b1, 1'b0);
      send_word(8'h63, 1'b1, 1'b1);
      send_word(8'h80, 1'b1, 1'b0);
      send_word(8'h7f, 1'b0, 1'b0);
      send_word(8'h01, 1'b1, 1'b0);
      send_word(8'hfe, 1'b0, 1'b1);
      send_word(8'h5a, 1'b0, 1'b1);
      items_sent = 12;

      // mostly short messages, some around the padding and block boundaries
      while (items_sent < ITEM_TARGET) begin
         tx_gappy = ($urandom_range(0, 2) != 0);
         if (items_sent >= QUIET_AFTER)
            quiet = 1'b1;
         if ($urandom_range(0, 5) == 0)
            n = pad_edge_lengths[$urandom_range(0, 6)];
         else
            n = $urandom_range(0, 24);
         send_message(n, 1'($urandom_range(0, 1)));
      end
      req_if.valid <= 1'b0;

      while (sb.pending_count() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
